// ===== hw/rtl/mcfb_pkg.sv =====
// Shared types and constants for the motor controller frame builder.
`default_nettype none

package mcfb_pkg;

  // Command field width and register data width
  localparam int CMD_W  = 2;
  localparam int ADDR_W = 2;
  localparam int CMD_VW = 15;
  localparam int CFG_IW = 2;

  // Scaled magnitude before division, and quotient width
  localparam int MAG_W  = 23;
  localparam int QUOT_W = 8;

  // Frame bytes and checksum bases
  localparam logic [7:0] BYTE_TEST    = 8'd251;
  localparam logic [7:0] BYTE_REVERSE = 8'd254;
  localparam logic [7:0] BYTE_SETADDR = 8'd250;
  localparam logic [7:0] SUM_TEST     = 8'd231;
  localparam logic [7:0] SUM_REVERSE  = 8'd234;
  localparam logic [7:0] SUM_SETADDR  = 8'd230;
  localparam logic [7:0] AXIS_MID     = 8'd100;
  localparam logic [7:0] AXIS_LIMIT   = 8'd100;
  localparam logic [7:0] THRUST_MAX   = 8'd200;
  localparam logic [7:0] THRUST_MIN   = 8'd1;
  localparam logic [MAG_W-1:0] AXIS_GAIN   = 23'd100;
  localparam logic [MAG_W-1:0] THRUST_GAIN = 23'd200;

  typedef enum logic [CMD_W-1:0] {
    CMD_NORMAL  = 2'd0,
    CMD_TEST    = 2'd1,
    CMD_REVERSE = 2'd2,
    CMD_SETADDR = 2'd3
  } cmd_e_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_TRIM_PITCH = 2'd0,
    REG_TRIM_ROLL  = 2'd1,
    REG_TRIM_YAW   = 2'd2,
    REG_KILL       = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } axis_mag_t;

  // Add trim, take magnitude, scale by the axis gain and cap the result
  function automatic axis_mag_t axis_mag(logic [CMD_VW-1:0] cmd, logic [CMD_VW-1:0] trim,
                                         logic [MAG_W-1:0] cap);
    logic [CMD_VW:0]  sum;
    logic [CMD_VW:0]  absval;
    logic [MAG_W-1:0] prod;
    axis_mag_t        res;
    sum    = {cmd[CMD_VW-1], cmd} + {trim[CMD_VW-1], trim};
    absval = sum[CMD_VW] ? (~sum + 1'b1) : sum;
    prod   = MAG_W'(absval) * AXIS_GAIN;
    res.neg = sum[CMD_VW];
    res.mag = (prod > cap) ? cap : prod;
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mcfb_div.sv =====
// Two-stage divider of a bounded magnitude by the full-scale constant.
`default_nettype none

module mcfb_div #(
  parameter int FULL_SCALE = 9600
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [mcfb_pkg::MAG_W-1:0]  mag,
  output logic      [mcfb_pkg::QUOT_W-1:0] quot
);
  import mcfb_pkg::*;

  localparam int RECIP_W = MAG_W + 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << MAG_W) / FULL_SCALE);
  localparam logic [MAG_W-1:0]   FS_C  = MAG_W'(FULL_SCALE);

  logic [MAG_W+RECIP_W-1:0] prod;
  logic [QUOT_W-1:0]        est;
  logic [MAG_W-1:0]         mag_q;
  logic [MAG_W-1:0]         rem;

  // Reciprocal estimate: never high, at most one low
  assign prod = (MAG_W+RECIP_W)'(mag) * (MAG_W+RECIP_W)'(RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      est   <= prod[MAG_W+QUOT_W-1:MAG_W];
      mag_q <= mag;
    end
  end

  // Correct the estimate by one remainder compare
  assign rem  = mag_q - MAG_W'(MAG_W'(est) * FS_C);
  assign quot = est + QUOT_W'(rem >= FS_C);

endmodule

`default_nettype wire

// ===== hw/rtl/motor_controller_frame_builder.sv =====
// Frame builder top: trims, scales and clamps commands into four-byte words.
// Latency: a result passes the input register, the scaling stage and the divider
// estimate register before it reaches the output registers.
// Throughput: one word per cycle while a finished word is not held by out_stall.
// Reset clears valids, trims, kill flag, stored address and error count.
`default_nettype none

module motor_controller_frame_builder #(
  parameter int FULL_SCALE = 9600
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [mcfb_pkg::CMD_VW-1:0] pitch_cmd,
  input  wire logic [mcfb_pkg::CMD_VW-1:0] roll_cmd,
  input  wire logic [mcfb_pkg::CMD_VW-1:0] yaw_cmd,
  input  wire logic [mcfb_pkg::CMD_VW-1:0] thrust_cmd,
  input  wire logic                        motor_run,
  input  wire logic                        bus_ok,
  input  wire logic [mcfb_pkg::CMD_W-1:0]  command,
  input  wire logic [mcfb_pkg::ADDR_W-1:0] new_address,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             frame_valid,
  output logic [7:0]                       byte0,
  output logic [7:0]                       byte1,
  output logic [7:0]                       byte2,
  output logic [7:0]                       byte3,
  output logic [15:0]                      error_total,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [mcfb_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [mcfb_pkg::CMD_VW-1:0] cfg_data
);
  import mcfb_pkg::*;

  localparam logic [MAG_W-1:0] AXIS_CAP   = MAG_W'(101 * FULL_SCALE);
  localparam logic [MAG_W-1:0] THRUST_CAP = MAG_W'(201 * FULL_SCALE);

  logic adv;

  // Configuration registers
  logic [CMD_VW-1:0] trim_pitch;
  logic [CMD_VW-1:0] trim_roll;
  logic [CMD_VW-1:0] trim_yaw;
  logic              kill_flag;

  // State
  logic [ADDR_W-1:0] current_address;
  logic [15:0]       error_count;

  // Input stage
  logic              v1;
  logic [CMD_VW-1:0] p1, r1, y1, t1;
  logic              mon1, ok1;
  logic [CMD_W-1:0]  cmd1;
  logic [ADDR_W-1:0] na1;

  // Scaling stage
  logic              va;
  axis_mag_t         pa, ra, ya;
  logic [MAG_W-1:0]  ta;
  logic              mona, oka;
  logic [CMD_W-1:0]  cmda;
  logic [ADDR_W-1:0] naa;

  // Divider stage
  logic              vb;
  logic              pnb, rnb, ynb;
  logic              monb, okb;
  logic [CMD_W-1:0]  cmdb;
  logic [ADDR_W-1:0] nab;

  logic [MAG_W-1:0]  t_prod;
  logic [MAG_W-1:0]  t_mag;
  logic [QUOT_W-1:0] qp, qr, qy, qt;
  logic [7:0]        cp, cr, cy, ct;
  logic [7:0]        b0_next, b1_next, b2_next, b3_next;

  // Whole pipeline moves unless a finished word is held
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      trim_pitch <= '0;
      trim_roll  <= '0;
      trim_yaw   <= '0;
      kill_flag  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_TRIM_PITCH: trim_pitch <= cfg_data;
        REG_TRIM_ROLL:  trim_roll  <= cfg_data;
        REG_TRIM_YAW:   trim_yaw   <= cfg_data;
        REG_KILL:       kill_flag  <= cfg_data[0];
        default:        kill_flag  <= kill_flag;
      endcase
    end
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1   <= pitch_cmd;
      r1   <= roll_cmd;
      y1   <= yaw_cmd;
      t1   <= thrust_cmd;
      mon1 <= motor_run;
      ok1  <= bus_ok;
      cmd1 <= command;
      na1  <= new_address;
    end
  end

  // Scale thrust; zero and negative commands give a zero quotient
  assign t_prod = MAG_W'(t1[CMD_VW-2:0]) * THRUST_GAIN;
  assign t_mag  = (t1[CMD_VW-1] || t1 == '0) ? '0 :
                  ((t_prod > THRUST_CAP) ? THRUST_CAP : t_prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (adv) begin
      va <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pa   <= axis_mag(p1, trim_pitch, AXIS_CAP);
      ra   <= axis_mag(r1, trim_roll, AXIS_CAP);
      ya   <= axis_mag(y1, trim_yaw, AXIS_CAP);
      ta   <= t_mag;
      mona <= mon1;
      oka  <= ok1;
      cmda <= cmd1;
      naa  <= na1;
    end
  end

  // Divide the four magnitudes by full scale
  mcfb_div #(.FULL_SCALE(FULL_SCALE)) u_div_pitch (
    .clk(clk), .en(adv), .mag(pa.mag), .quot(qp)
  );
  mcfb_div #(.FULL_SCALE(FULL_SCALE)) u_div_roll (
    .clk(clk), .en(adv), .mag(ra.mag), .quot(qr)
  );
  mcfb_div #(.FULL_SCALE(FULL_SCALE)) u_div_yaw (
    .clk(clk), .en(adv), .mag(ya.mag), .quot(qy)
  );
  mcfb_div #(.FULL_SCALE(FULL_SCALE)) u_div_thrust (
    .clk(clk), .en(adv), .mag(ta), .quot(qt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (adv) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pnb  <= pa.neg;
      rnb  <= ra.neg;
      ynb  <= ya.neg;
      monb <= mona;
      okb  <= oka;
      cmdb <= cmda;
      nab  <= naa;
    end
  end

  // Clamp the quotients; kill forces everything to zero
  always_comb begin
    cp = (qp > AXIS_LIMIT) ? AXIS_LIMIT : qp;
    cr = (qr > AXIS_LIMIT) ? AXIS_LIMIT : qr;
    cy = (qy > AXIS_LIMIT) ? AXIS_LIMIT : qy;
    if (!monb) begin
      ct = '0;
    end else if (qt == '0) begin
      ct = THRUST_MIN;
    end else if (qt > THRUST_MAX) begin
      ct = THRUST_MAX;
    end else begin
      ct = qt;
    end
    if (kill_flag) begin
      cp = '0;
      cr = '0;
      cy = '0;
      ct = '0;
    end
  end

  // Build the frame bytes
  always_comb begin
    case (cmd_e_t'(cmdb))
      CMD_TEST: begin
        b0_next = BYTE_TEST;
        b1_next = 8'(current_address);
        b2_next = '0;
        b3_next = SUM_TEST + 8'(current_address);
      end
      CMD_REVERSE: begin
        b0_next = BYTE_REVERSE;
        b1_next = 8'(current_address);
        b2_next = '0;
        b3_next = SUM_REVERSE + 8'(current_address);
      end
      CMD_SETADDR: begin
        b0_next = BYTE_SETADDR;
        b1_next = 8'(current_address);
        b2_next = 8'(nab);
        b3_next = SUM_SETADDR + 8'(current_address) + 8'(nab);
      end
      default: begin
        b0_next = pnb ? AXIS_MID + cp : AXIS_MID - cp;
        b1_next = rnb ? AXIS_MID - cr : AXIS_MID + cr;
        b2_next = ynb ? AXIS_MID + cy : AXIS_MID - cy;
        b3_next = ct;
      end
    endcase
    if (!okb) begin
      b0_next = '0;
      b1_next = '0;
      b2_next = '0;
      b3_next = '0;
    end
  end

  // Update stored address and error count as each word leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      current_address <= '0;
      error_count     <= '0;
    end else if (adv && vb) begin
      if (!okb) begin
        error_count <= error_count + 16'd1;
      end else if (cmd_e_t'(cmdb) == CMD_SETADDR) begin
        current_address <= nab;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      frame_valid <= okb;
      byte0       <= b0_next;
      byte1       <= b1_next;
      byte2       <= b2_next;
      byte3       <= b3_next;
      error_total <= okb ? error_count : error_count + 16'd1;
    end
  end

endmodule

`default_nettype wire
